### hw/rtl/sta_pkg.sv
package sta_pkg;

    localparam int DATA_W    = 32;
    localparam int LEN_W     = 9;
    localparam int ACC_W     = 41;          // |avg*(n-1)+x| <= 511 * 2^31 < 2^40
    localparam int MAG_W     = ACC_W - 1;
    localparam int REM_W     = LEN_W + 1;
    localparam int DIV_STEPS = MAG_W;       // one quotient bit per cycle
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);

    // controller -> datapath
    typedef struct packed {
        logic take;        // input transfer this cycle
        logic mul;         // avg * (n-1)
        logic add;         // + x
        logic load_div;    // magnitude into divider
        logic div_step;    // one restoring step
        logic finish;      // write back, emit, update count
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;  // store empty: item only seeds
        logic finish_ok;   // output register can take the result
    } t_dp_sts;

endpackage

### hw/rtl/sta_ifs.sv
interface sta_in_if import sta_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] bin_sample;
    logic                     sweep_end;

    modport source (output valid, output bin_sample, output sweep_end, input ready);
    modport sink   (input valid, input bin_sample, input sweep_end, output ready);
endinterface

interface sta_out_if import sta_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] averaged_bin;
    logic                     last_bin;

    modport source (output valid, output averaged_bin, output last_bin, input ready);
    modport sink   (input valid, input averaged_bin, input last_bin, output ready);
endinterface

### hw/rtl/sweep_trace_averager.sv
// Channel   Dir  Payload                               Transfer
// i_in      in   bin_sample s32 Q16.16, sweep_end      valid & ready
// o_out     out  averaged_bin s32 Q16.16, last_bin     valid & ready
// i_cfg_*   in   average_length u9 (N, reset 8)        i_cfg_we
//
// Seeding sample (store empty): the sample goes straight to the store.
// Averaging sample: read, multiply, add, magnitude, radix-2 restoring divide
//   by n, write back; the divide is the longest step.
// A finished result sits in the output register; the next sample is taken
//   while it waits. Only a second result stalls (in its write-back cycle).
// Reset: synchronous; N = 8, store marked empty. Store contents are not cleared.
module sweep_trace_averager import sta_pkg::*; #(
    parameter int MAX_BINS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_data,
    sta_in_if.sink           i_in,
    sta_out_if.source        o_out
);

    localparam int AW = $clog2(MAX_BINS);

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic              in_ready;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    // sequencer: one sample at a time through mul / add / divide
    sta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // arithmetic, counters and output register
    sta_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_bin_sample   (i_in.bin_sample),
        .i_sweep_end    (i_in.sweep_end),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_averaged_bin (o_out.averaged_bin),
        .o_last_bin     (o_out.last_bin)
    );

    // per-bin running averages
    sta_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_BINS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

### hw/rtl/sta_ram.sv
module sta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/sta_ctrl.sv
module sta_ctrl import sta_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_ABS  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (!i_sts.count_zero) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_ABS;
            end
            S_ABS: begin
                o_cmd.load_div = 1'b1;
                n_step         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.finish_ok) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

### hw/rtl/sta_dp.sv
module sta_dp import sta_pkg::*; #(
    parameter int MAX_BINS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [LEN_W-1:0]            i_cfg_data,
    input  logic signed [DATA_W-1:0]    i_bin_sample,
    input  logic                        i_sweep_end,
    input  t_dp_cmd                     i_cmd,
    output t_dp_sts                     o_sts,
    output logic                        o_ram_we,
    output logic [$clog2(MAX_BINS)-1:0] o_ram_waddr,
    output logic [DATA_W-1:0]           o_ram_wdata,
    output logic [$clog2(MAX_BINS)-1:0] o_ram_raddr,
    input  logic [DATA_W-1:0]           i_ram_rdata,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [DATA_W-1:0]    o_averaged_bin,
    output logic                        o_last_bin
);

    localparam int AW = $clog2(MAX_BINS);

    logic [LEN_W-1:0]         r_len;
    logic [LEN_W-1:0]         r_count;
    logic [AW-1:0]            r_pos;
    logic signed [DATA_W-1:0] r_x;
    logic                     r_end;
    logic [AW-1:0]            r_wpos;
    logic [LEN_W-1:0]         r_n;
    logic                     r_emit;
    logic signed [ACC_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_neg;
    logic [MAG_W-1:0]         r_div;
    logic [REM_W-1:0]         r_rem;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_bin;
    logic                     r_out_last;

    logic [LEN_W-1:0]         len_eff;
    logic [LEN_W:0]           cnt_inc;
    logic [LEN_W-1:0]         n_sel;
    logic [AW-1:0]            pos_next;
    logic [LEN_W-1:0]         nm1;
    logic signed [DATA_W-1:0] avg_old;
    logic [REM_W-1:0]         rem_sh;
    logic                     rem_ge;
    logic [MAG_W-1:0]         mag_neg;
    logic [DATA_W-1:0]        q_sat;

    // length 0 behaves as 1
    assign len_eff  = (r_len == '0) ? LEN_W'(1) : r_len;
    assign cnt_inc  = {1'b0, r_count} + 1'b1;
    assign n_sel    = (cnt_inc > {1'b0, len_eff}) ? len_eff : cnt_inc[LEN_W-1:0];
    assign pos_next = (r_pos == AW'(MAX_BINS - 1)) ? '0 : r_pos + 1'b1;
    assign nm1      = r_n - 1'b1;
    assign avg_old  = $signed(i_ram_rdata);

    // restoring divide step
    assign rem_sh = {r_rem[REM_W-2:0], r_div[MAG_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_n});

    // quotient magnitude -> signed, saturated
    assign mag_neg = ~r_div + 1'b1;
    always_comb begin
        if (r_neg) begin
            if ((|r_div[MAG_W-1:DATA_W]) || (r_div[DATA_W-1] && (|r_div[DATA_W-2:0]))) begin
                q_sat = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                q_sat = mag_neg[DATA_W-1:0];
            end
        end else begin
            if (|r_div[MAG_W-1:DATA_W-1]) begin
                q_sat = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                q_sat = r_div[DATA_W-1:0];
            end
        end
    end

    // seeding writes the raw sample at accept; averaging writes back at finish
    assign o_ram_we    = (i_cmd.take && o_sts.count_zero) || i_cmd.finish;
    assign o_ram_waddr = i_cmd.take ? r_pos : r_wpos;
    assign o_ram_wdata = i_cmd.take ? i_bin_sample : q_sat;
    assign o_ram_raddr = r_pos;

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.finish_ok  = !r_emit || !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_RESET;
            r_count <= '0;
            r_pos   <= '0;
        end else if (i_cfg_we) begin
            r_len   <= i_cfg_data;
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.take) begin
                r_pos <= i_sweep_end ? '0 : pos_next;
                if (o_sts.count_zero && i_sweep_end) begin
                    r_count <= LEN_W'(1);
                end
            end
            if (i_cmd.finish && r_end) begin
                r_count <= (r_n == len_eff) ? '0 : r_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_x    <= i_bin_sample;
            r_end  <= i_sweep_end;
            r_wpos <= r_pos;
            r_n    <= n_sel;
            r_emit <= (n_sel == len_eff);
        end
        if (i_cmd.mul) begin
            r_prod <= avg_old * $signed({1'b0, nm1});
        end
        if (i_cmd.add) begin
            r_acc <= r_prod + ACC_W'(r_x);
        end
        if (i_cmd.load_div) begin
            r_neg <= r_acc[ACC_W-1];
            r_div <= r_acc[ACC_W-1] ? MAG_W'(-r_acc) : r_acc[MAG_W-1:0];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? (rem_sh - {1'b0, r_n}) : rem_sh;
            r_div <= {r_div[MAG_W-2:0], rem_ge};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish && r_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_emit) begin
            r_out_bin  <= $signed(q_sat);
            r_out_last <= r_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_averaged_bin = r_out_bin;
    assign o_last_bin     = r_out_last;

endmodule

### hw/rtl/sta_checker.sv
module sta_checker import sta_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_averaged_bin,
    input logic              i_last_bin
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a result is produced only from the write-back cycle, when input is blocked
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a busy cycle");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_averaged_bin) && $stable(i_last_bin))
        else $error("output payload changed while stalled");

endmodule

bind sweep_trace_averager sta_checker u_sta_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_averaged_bin (o_out.averaged_bin),
    .i_last_bin     (o_out.last_bin)
);
